### hw/rtl/twcl_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants for the test waveform and capture log block.
// Also holds the elaboration-time quarter-wave sine function used to build the sine table.
// No dependencies.
package twcl_pkg;

    localparam int unsigned COLUMNS = 7;
    localparam int unsigned DATA_W = 32;
    localparam int unsigned UNIT_W = 18;
    localparam int unsigned PROD_W = 50;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_START = 2'd1,
        OP_READ  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        LOG_READY   = 2'd0,
        LOG_RUNNING = 2'd1,
        LOG_FULL    = 2'd2
    } log_t;

    typedef enum logic [1:0] {
        WAVE_SQUARE   = 2'd0,
        WAVE_SINE     = 2'd1,
        WAVE_TRIANGLE = 2'd2,
        WAVE_ZERO     = 2'd3
    } wave_t;

    localparam logic [2:0] CFG_KIND       = 3'd0;
    localparam logic [2:0] CFG_AMPLITUDE  = 3'd1;
    localparam logic [2:0] CFG_OFFSET     = 3'd2;
    localparam logic [2:0] CFG_RATE       = 3'd3;
    localparam logic [2:0] CFG_DECIMATION = 3'd4;

    // Quarter-wave sine in Q16 from an angle in Q30, by a truncated Taylor series.
    function automatic logic [16:0] quarter_sine(input logic [63:0] x);
        logic [63:0] x2;
        logic [63:0] term;
        logic signed [65:0] sum;
        logic [65:0] q;
        begin
            x2 = (x * x) >> 30;
            term = x;
            sum = $signed({2'b00, x});
            term = ((term * x2) >> 30) / 64'd6;
            sum = sum - $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd20;
            sum = sum + $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd42;
            sum = sum - $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd72;
            sum = sum + $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd110;
            sum = sum - $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd156;
            sum = sum + $signed({2'b00, term});
            term = ((term * x2) >> 30) / 64'd210;
            sum = sum - $signed({2'b00, term});
            if (sum < 0)
            begin
                sum = '0;
            end
            q = ($unsigned(sum) + 66'd8192) >> 14;
            if (q > 66'd65536)
            begin
                q = 66'd65536;
            end
            quarter_sine = q[16:0];
        end
    endfunction

endpackage

### hw/rtl/test_waveform_and_capture_log.sv
`timescale 1ns / 1ps
// Top level of the test waveform generator with its decimating capture log.
// Depends on twcl_pkg for codes, widths and the sine table function.

// One item is taken at a time, and in_ready is high only while the block is idle.
// A sample tick while logging takes the transfer, runs a bit-serial multiply for the
// phase, picks the unit value, reads the sine table (sine wave only), runs a
// bit-serial multiply by the amplitude, rounds and saturates, and loads the output
// register. A tick that stores a row also writes the row word by word through the
// single write port of the capture memory. With the zero waveform the amplitude
// multiply is skipped. A tick outside logging, a start or an unused code goes from
// taking the transfer straight to loading the output register, and a read adds a
// memory read between the two. While the previous result still waits in the output
// register, the item holds in its last cycle.
// The capture memory needs no clearing after reset: rows are always written from
// row zero upward, so a high-water mark tells which rows read back as zero.
module test_waveform_and_capture_log #(
    parameter int unsigned ROWS = 512,
    parameter int unsigned SINE_POINTS = 1024
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_write,
    input  logic [2:0]          cfg_index,
    input  logic [31:0]         cfg_data,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          operation,
    input  logic [31:0]         time_now,
    input  logic signed [31:0]  sample_a,
    input  logic signed [31:0]  sample_b,
    input  logic signed [31:0]  sample_c,
    input  logic signed [31:0]  sample_d,
    input  logic signed [31:0]  sample_e,
    input  logic signed [31:0]  sample_f,
    input  logic [8:0]          read_row,
    input  logic [2:0]          read_column,
    output logic                out_valid,
    input  logic                out_ready,
    output logic signed [31:0]  set_value,
    output logic [1:0]          log_state,
    output logic signed [31:0]  read_word
);

    localparam int unsigned DEPTH = ROWS * twcl_pkg::COLUMNS;
    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned RW = $clog2(ROWS + 1);
    localparam int unsigned SW = $clog2(SINE_POINTS);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_PHASE,
        ST_PREP,
        ST_SINE_RD,
        ST_MUL_AMP,
        ST_FINISH,
        ST_STORE,
        ST_READ,
        ST_DONE
    } state_t;

    logic signed [twcl_pkg::UNIT_W-1:0] sine_rom [SINE_POINTS];

    for (genvar k = 0; k < SINE_POINTS; k++)
    begin : g_sine
        localparam int unsigned M = 4 * k;
        localparam int unsigned QUAD = M / SINE_POINTS;
        localparam int unsigned R0 = M % SINE_POINTS;
        localparam int unsigned R = ((QUAD % 2) == 1) ? (SINE_POINTS - R0) : R0;
        localparam logic [63:0] X = (twcl_pkg::HALF_PI_Q30 * 64'(R)) / 64'(SINE_POINTS);
        localparam logic [16:0] V = twcl_pkg::quarter_sine(X);
        assign sine_rom[k] = (QUAD >= 2) ? -$signed({1'b0, V}) : $signed({1'b0, V});
    end

    state_t state_reg;
    twcl_pkg::wave_t kind_reg;
    logic signed [31:0] amplitude_reg;
    logic signed [31:0] offset_reg;
    logic [31:0] rate_reg;
    logic [15:0] decimation_reg;

    twcl_pkg::log_t phase_reg;
    logic [RW-1:0] row_count_reg;
    logic [RW-1:0] high_water_reg;
    logic [15:0] dcnt_reg;
    logic [31:0] origin_reg;

    logic [4:0] bit_cnt_reg;
    logic [31:0] acc_reg;
    logic [31:0] mcand_reg;
    logic [31:0] mplier_reg;
    logic [SW-1:0] sidx_reg;
    logic signed [twcl_pkg::UNIT_W-1:0] unit_reg;
    logic signed [twcl_pkg::PROD_W-1:0] prod_reg;
    logic signed [twcl_pkg::PROD_W-1:0] amp_sh_reg;

    logic store_pend_reg;
    logic [2:0] st_cnt_reg;
    logic [31:0] st_word_reg [twcl_pkg::COLUMNS];
    logic [AW-1:0] wr_addr_reg;
    logic [AW-1:0] rd_addr_reg;
    logic rd_ok_reg;
    logic [31:0] rd_data_reg;
    logic signed [31:0] res_set_reg;
    twcl_pkg::log_t res_log_reg;

    logic out_valid_reg;
    logic signed [31:0] out_set_reg;
    logic [1:0] out_log_reg;
    logic signed [31:0] out_word_reg;

    logic mem_we;
    logic [31:0] mem [DEPTH];

    logic [15:0] dcnt_next;
    logic [31:0] origin_next;
    logic [31:0] rel_next;
    logic [32+SW:0] sidx_prod;
    logic [twcl_pkg::UNIT_W-1:0] tri_f;
    logic signed [twcl_pkg::PROD_W-1:0] rounded;
    logic signed [34:0] shifted;
    logic signed [34:0] summed;
    logic signed [31:0] sat_value;

    assign in_ready = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign set_value = out_set_reg;
    assign log_state = out_log_reg;
    assign read_word = out_word_reg;
    assign mem_we = (state_reg == ST_STORE);

    always_comb
    begin
        dcnt_next = dcnt_reg + 16'd1;
        origin_next = (row_count_reg == '0) ? time_now : origin_reg;
        rel_next = time_now - origin_next;
        sidx_prod = {{(SW + 1){1'b0}}, acc_reg} * (33 + SW)'(SINE_POINTS);
        tri_f = acc_reg[31:14];
        rounded = prod_reg + twcl_pkg::PROD_W'(32768);
        shifted = 35'(rounded >>> 16);
        summed = shifted + 35'(offset_reg);
        if (summed > 35'sh0_7FFF_FFFF)
        begin
            sat_value = 32'sh7FFF_FFFF;
        end
        else if (summed < -35'sh0_8000_0000)
        begin
            sat_value = -32'sh8000_0000;
        end
        else
        begin
            sat_value = summed[31:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[wr_addr_reg] <= st_word_reg[0];
        end
        rd_data_reg <= mem[rd_addr_reg];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            kind_reg <= twcl_pkg::WAVE_SQUARE;
            amplitude_reg <= '0;
            offset_reg <= '0;
            rate_reg <= '0;
            decimation_reg <= 16'd1;
            phase_reg <= twcl_pkg::LOG_READY;
            row_count_reg <= '0;
            high_water_reg <= '0;
            dcnt_reg <= '0;
            origin_reg <= '0;
            bit_cnt_reg <= '0;
            acc_reg <= '0;
            mcand_reg <= '0;
            mplier_reg <= '0;
            sidx_reg <= '0;
            unit_reg <= '0;
            prod_reg <= '0;
            amp_sh_reg <= '0;
            store_pend_reg <= 1'b0;
            st_cnt_reg <= '0;
            for (int i = 0; i < twcl_pkg::COLUMNS; i++)
            begin
                st_word_reg[i] <= '0;
            end
            wr_addr_reg <= '0;
            rd_addr_reg <= '0;
            rd_ok_reg <= 1'b0;
            res_set_reg <= '0;
            res_log_reg <= twcl_pkg::LOG_READY;
            out_valid_reg <= 1'b0;
            out_set_reg <= '0;
            out_log_reg <= '0;
            out_word_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                case (cfg_index)
                    twcl_pkg::CFG_KIND:       kind_reg <= twcl_pkg::wave_t'(cfg_data[1:0]);
                    twcl_pkg::CFG_AMPLITUDE:  amplitude_reg <= cfg_data;
                    twcl_pkg::CFG_OFFSET:     offset_reg <= cfg_data;
                    twcl_pkg::CFG_RATE:       rate_reg <= cfg_data;
                    twcl_pkg::CFG_DECIMATION: decimation_reg <= cfg_data[15:0];
                    default: ;
                endcase
            end

            if (out_valid_reg && out_ready && (state_reg != ST_DONE))
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (in_valid)
                    begin
                        res_set_reg <= '0;
                        rd_ok_reg <= 1'b0;
                        store_pend_reg <= 1'b0;
                        res_log_reg <= phase_reg;
                        state_reg <= ST_DONE;
                        case (operation)
                            twcl_pkg::OP_TICK:
                            begin
                                if (phase_reg == twcl_pkg::LOG_RUNNING)
                                begin
                                    origin_reg <= origin_next;
                                    acc_reg <= '0;
                                    mcand_reg <= rate_reg;
                                    mplier_reg <= rel_next;
                                    bit_cnt_reg <= '0;
                                    state_reg <= ST_MUL_PHASE;
                                    st_word_reg[0] <= rel_next;
                                    st_word_reg[1] <= sample_a;
                                    st_word_reg[2] <= sample_b;
                                    st_word_reg[3] <= sample_c;
                                    st_word_reg[4] <= sample_d;
                                    st_word_reg[5] <= sample_e;
                                    st_word_reg[6] <= sample_f;
                                    wr_addr_reg <= AW'(row_count_reg) * AW'(twcl_pkg::COLUMNS);
                                    st_cnt_reg <= '0;
                                    if (dcnt_next == decimation_reg)
                                    begin
                                        dcnt_reg <= '0;
                                        store_pend_reg <= 1'b1;
                                        row_count_reg <= row_count_reg + 1'b1;
                                        if (row_count_reg + 1'b1 > high_water_reg)
                                        begin
                                            high_water_reg <= row_count_reg + 1'b1;
                                        end
                                        if (32'(row_count_reg) + 32'd1 >= ROWS)
                                        begin
                                            phase_reg <= twcl_pkg::LOG_FULL;
                                            res_log_reg <= twcl_pkg::LOG_FULL;
                                        end
                                    end
                                    else
                                    begin
                                        dcnt_reg <= dcnt_next;
                                    end
                                end
                            end
                            twcl_pkg::OP_START:
                            begin
                                phase_reg <= twcl_pkg::LOG_RUNNING;
                                res_log_reg <= twcl_pkg::LOG_RUNNING;
                                row_count_reg <= '0;
                                dcnt_reg <= '0;
                            end
                            twcl_pkg::OP_READ:
                            begin
                                rd_ok_reg <= ({23'd0, read_row} < 32'(high_water_reg))
                                    && (read_column < 3'(twcl_pkg::COLUMNS));
                                rd_addr_reg <= AW'(read_row) * AW'(twcl_pkg::COLUMNS)
                                    + AW'(read_column);
                                state_reg <= ST_READ;
                            end
                            default: ;
                        endcase
                    end
                end

                ST_MUL_PHASE:
                begin
                    if (mplier_reg[0])
                    begin
                        acc_reg <= acc_reg + mcand_reg;
                    end
                    mcand_reg <= mcand_reg << 1;
                    mplier_reg <= mplier_reg >> 1;
                    bit_cnt_reg <= bit_cnt_reg + 5'd1;
                    if (bit_cnt_reg == 5'd31)
                    begin
                        state_reg <= ST_PREP;
                    end
                end

                ST_PREP:
                begin
                    bit_cnt_reg <= '0;
                    prod_reg <= '0;
                    amp_sh_reg <= twcl_pkg::PROD_W'(amplitude_reg);
                    sidx_reg <= sidx_prod[32 +: SW];
                    state_reg <= ST_MUL_AMP;
                    case (kind_reg)
                        twcl_pkg::WAVE_SQUARE:
                        begin
                            unit_reg <= acc_reg[31] ? -18'sd65536 : 18'sd65536;
                        end
                        twcl_pkg::WAVE_SINE:
                        begin
                            state_reg <= ST_SINE_RD;
                        end
                        twcl_pkg::WAVE_TRIANGLE:
                        begin
                            if (acc_reg <= 32'h8000_0000)
                            begin
                                unit_reg <= $signed(tri_f) - 18'sd65536;
                            end
                            else
                            begin
                                unit_reg <= 18'sd196608 - $signed(tri_f);
                            end
                        end
                        default:
                        begin
                            res_set_reg <= '0;
                            state_reg <= store_pend_reg ? ST_STORE : ST_DONE;
                        end
                    endcase
                end

                ST_SINE_RD:
                begin
                    unit_reg <= sine_rom[sidx_reg];
                    state_reg <= ST_MUL_AMP;
                end

                ST_MUL_AMP:
                begin
                    if (unit_reg[0])
                    begin
                        if (bit_cnt_reg == 5'(twcl_pkg::UNIT_W - 1))
                        begin
                            prod_reg <= prod_reg - amp_sh_reg;
                        end
                        else
                        begin
                            prod_reg <= prod_reg + amp_sh_reg;
                        end
                    end
                    amp_sh_reg <= amp_sh_reg <<< 1;
                    unit_reg <= unit_reg >>> 1;
                    bit_cnt_reg <= bit_cnt_reg + 5'd1;
                    if (bit_cnt_reg == 5'(twcl_pkg::UNIT_W - 1))
                    begin
                        state_reg <= ST_FINISH;
                    end
                end

                ST_FINISH:
                begin
                    res_set_reg <= sat_value;
                    state_reg <= store_pend_reg ? ST_STORE : ST_DONE;
                end

                ST_STORE:
                begin
                    for (int i = 0; i < twcl_pkg::COLUMNS - 1; i++)
                    begin
                        st_word_reg[i] <= st_word_reg[i + 1];
                    end
                    wr_addr_reg <= wr_addr_reg + 1'b1;
                    st_cnt_reg <= st_cnt_reg + 3'd1;
                    if (st_cnt_reg == 3'(twcl_pkg::COLUMNS - 1))
                    begin
                        state_reg <= ST_DONE;
                    end
                end

                ST_READ:
                begin
                    state_reg <= ST_DONE;
                end

                ST_DONE:
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_reg <= 1'b1;
                        out_set_reg <= res_set_reg;
                        out_log_reg <= res_log_reg;
                        out_word_reg <= rd_ok_reg ? rd_data_reg : '0;
                        state_reg <= ST_IDLE;
                    end
                end

                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n)
        row_count_reg <= high_water_reg)
        else $error("Row count ran past the high-water mark.");

    assert property (@(posedge clk) disable iff (!rst_n)
        32'(high_water_reg) <= ROWS)
        else $error("High-water mark exceeds the number of rows.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_STORE) |-> store_pend_reg && (phase_reg != twcl_pkg::LOG_READY))
        else $error("Row write without a pending store.");

    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready)
        else $error("Second transfer taken while an item is in progress.");
`endif

endmodule
